>>> sv/skcm_pkg.sv
// Shared types and constants of the sorted key count merge table.
package skcm_pkg;

	localparam int KEY_W   = 32;
	localparam int QTY_W   = 16;
	localparam int CNT_W   = 32;
	localparam int RANK_W  = 6;
	localparam int USED_W  = 7;
	localparam int RANK_SPAN = 1 << RANK_W;

	localparam logic MODE_ADD  = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// Command broadcast to every cell in the chain.
	typedef struct packed {
		logic             ins_en;
		logic             mrg_en;
		logic [KEY_W-1:0] key;
		logic [QTY_W-1:0] qty;
	} skcm_cmd_t;

	// Entry handed from one cell to the next.
	typedef struct packed {
		logic             gt;
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] count;
	} skcm_link_t;

endpackage

>>> sv/skcm_cell.sv
// One table cell: holds an entry, compares it with the broadcast key, shifts or merges.
module skcm_cell
	import skcm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  skcm_cmd_t        cmd,
	input  skcm_link_t       prev,
	output skcm_link_t       link,
	output logic             match,
	output logic [CNT_W-1:0] sum
);

	logic             valid_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W:0]   raw_sum;

	assign raw_sum = {1'b0, count_q} + {{(CNT_W + 1 - QTY_W){1'b0}}, cmd.qty};
	assign sum     = raw_sum[CNT_W] ? {CNT_W{1'b1}} : raw_sum[CNT_W-1:0];
	assign match   = valid_q && (key_q == cmd.key);

	assign link.gt    = valid_q && (key_q > cmd.key);
	assign link.valid = valid_q;
	assign link.key   = key_q;
	assign link.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins_en && !link.gt) begin
			valid_q <= prev.gt ? 1'b1 : prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_en && !link.gt) begin
			// first cell not above the new key takes it, cells below take their neighbor
			if (prev.gt) begin
				key_q   <= cmd.key;
				count_q <= {{(CNT_W - QTY_W){1'b0}}, cmd.qty};
			end else begin
				key_q   <= prev.key;
				count_q <= prev.count;
			end
		end else if (cmd.mrg_en && match) begin
			count_q <= sum;
		end
	end

endmodule

>>> sv/sorted_key_count_merge_table.sv
// Top level of the sorted key count merge table: cell chain, fill count and result register.
//
//   channel  | handshake          | fields
//   ---------+--------------------+--------------------------------------------------
//   input    | in_valid, in_stall | mode, part_key, quantity, rank
//   output   | out_valid,out_stall| entry_key, entry_count, entry_present, was_merged,
//            |                    | dropped_full, entries_used
//
// One item per cycle while the output is not stalled: all cells compare against the key
// in parallel and shift or merge at the edge that also loads the result into the output register.
// Reset clears every cell's valid bit and the fill count at once; no clearing pass.
// Input stalls only while a held result is itself stalled at the output.
module sorted_key_count_merge_table
	import skcm_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              mode,
	input  logic [KEY_W-1:0]  part_key,
	input  logic [QTY_W-1:0]  quantity,
	input  logic [RANK_W-1:0] rank,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [KEY_W-1:0]  entry_key,
	output logic [CNT_W-1:0]  entry_count,
	output logic              entry_present,
	output logic              was_merged,
	output logic              dropped_full,
	output logic [USED_W-1:0] entries_used
);

	localparam int UW = $clog2(CAPACITY + 1);

	skcm_cmd_t          cmd;
	skcm_link_t         links [CAPACITY+1];
	logic [CNT_W-1:0]   sums  [CAPACITY];
	logic [CAPACITY-1:0] match_vec;
	logic [CAPACITY-1:0] valid_vec;
	logic [UW-1:0]      used_q;
	logic               in_xfer;
	logic               is_add;
	logic               any_match;
	logic               full;
	logic               rank_hit;
	logic [KEY_W-1:0]   rd_key;
	logic [CNT_W-1:0]   rd_count;
	logic [CNT_W-1:0]   mrg_sum;
	logic [UW-1:0]      used_next;

	logic [KEY_W-1:0]   res_key;
	logic [CNT_W-1:0]   res_count;
	logic               res_present;
	logic               res_merged;
	logic               res_dropped;

	assign in_stall  = out_valid && out_stall;
	assign in_xfer   = in_valid && !in_stall;
	assign is_add    = (mode == MODE_ADD);
	assign any_match = |match_vec;
	assign full      = (used_q == UW'(CAPACITY));

	assign cmd.key    = part_key;
	assign cmd.qty    = quantity;
	assign cmd.mrg_en = in_xfer && is_add && any_match;
	assign cmd.ins_en = in_xfer && is_add && !any_match && !full;

	// head of the chain always sits above the new key
	assign links[0].gt    = 1'b1;
	assign links[0].valid = 1'b0;
	assign links[0].key   = '0;
	assign links[0].count = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		skcm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.prev   (links[i]),
			.link   (links[i+1]),
			.match  (match_vec[i]),
			.sum    (sums[i])
		);
		assign valid_vec[i] = links[i+1].valid;
	end

	// Select the ranked entry and the merged count by one-hot OR across cells.
	always_comb begin
		rd_key   = '0;
		rd_count = '0;
		mrg_sum  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (i < RANK_SPAN && rank == RANK_W'(i) && links[i+1].valid) begin
				rd_key   = rd_key | links[i+1].key;
				rd_count = rd_count | links[i+1].count;
			end
			if (match_vec[i]) begin
				mrg_sum = mrg_sum | sums[i];
			end
		end
	end

	assign rank_hit  = (32'(rank) < 32'(used_q));
	assign used_next = cmd.ins_en ? used_q + UW'(1) : used_q;

	always_comb begin
		res_key     = part_key;
		res_count   = '0;
		res_present = 1'b0;
		res_merged  = 1'b0;
		res_dropped = 1'b0;
		if (!is_add) begin
			res_key     = rank_hit ? rd_key : '0;
			res_count   = rank_hit ? rd_count : '0;
			res_present = rank_hit;
		end else if (any_match) begin
			res_count   = mrg_sum;
			res_present = 1'b1;
			res_merged  = 1'b1;
		end else if (full) begin
			res_dropped = 1'b1;
		end else begin
			res_count   = {{(CNT_W - QTY_W){1'b0}}, quantity};
			res_present = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			used_q <= used_next;
			if (in_xfer) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// hold the result while stalled
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			entry_key     <= res_key;
			entry_count   <= res_count;
			entry_present <= res_present;
			was_merged    <= res_merged;
			dropped_full  <= res_dropped;
			entries_used  <= USED_W'(32'(used_next));
		end
	end

	a_used_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(used_q))
		else $error("fill count disagrees with valid cells");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("key held in more than one cell");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_en |=> used_q == $past(used_q) + UW'(1))
		else $error("insert did not grow the table");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(was_merged && dropped_full) && !(dropped_full && entry_present))
		else $error("conflicting result flags");

endmodule
